FILE: sv/fsg_pkg.sv
`timescale 1ns / 1ps
// Package for the falling-sand grid step block: cell, command and result types.
// No dependencies; imported by every module of the block.
package fsg_pkg;

    // Cell codes as stored in the grid
    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_SAND  = 2'd1;
    localparam logic [1:0] CELL_WATER = 2'd2;
    localparam logic [1:0] CELL_WALL  = 2'd3;

    // Command kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_SWEEP = 2'd2;

    // Galois LFSR feedback taps, right-shifting
    localparam logic [31:0] LFSR_TAPS = 32'hA300_0000;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] cell_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0] cell_out;
        logic [1:0] done_kind;
    } res_t;

endpackage

FILE: sv/falling_sand_grid_step_top.sv
`timescale 1ns / 1ps
// Falling-sand grid step, one item at a time; busy is high while a write, read or sweep runs
// and stays low for an unused kind. Done is registered: a write passes S_WR, a read S_RD and
// S_RD_EV, and an unused kind is answered straight from idle. Sweep: (ROWS-1)*COLS cells,
// bottom-up, each one paced by the single grid port.
// Reset: async, active low; lfsr loads 1, then a clearing pass over all 2^AW addresses
// (4096 at 64x64) empties the grid, busy high. No receiver stall; seed writes when idle.
module falling_sand_grid_step_top
    import fsg_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        done,
    output res_t        result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int AW = RW + CW;

    // grid port, driven by the sequencer
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [1:0]    mem_rdata;

    // one LFSR step per direction draw
    logic          draw;
    logic          dir;

    fsg_lfsr u_lfsr
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (cfg_we),
        .seed    (cfg_data),
        .draw    (draw),
        .dir     (dir)
    );

    // grid held as {row, col} addressed store
    fsg_grid_mem #(
        .AW (AW)
    ) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer: bottom-up, left-to-right sweep, one cell access per cycle
    fsg_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .draw      (draw),
        .dir       (dir)
    );

endmodule

FILE: sv/fsg_grid_mem.sv
`timescale 1ns / 1ps
// Grid store: one write port, one read port with registered read data.
// Depends on fsg_pkg.
module fsg_grid_mem
    import fsg_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    localparam int DEPTH = 1 << AW;

    logic [1:0] mem_reg [0:DEPTH-1];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read-first: a same-cycle write is not seen
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fsg_lfsr.sv
`timescale 1ns / 1ps
// Direction generator: 32-bit right-shifting Galois LFSR, one step per draw.
// Depends on fsg_pkg.
module fsg_lfsr
    import fsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed,
    input  logic        draw,
    output logic        dir
);

    logic [31:0] lfsr_reg;
    logic [31:0] lfsr_next;
    logic [31:0] step;

    always_comb
    begin
        step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
        lfsr_next = lfsr_reg;
        if (seed_we)
        begin
            // zero seed would lock up; load one instead
            lfsr_next = (seed == 32'd0) ? 32'd1 : seed;
        end
        else if (draw)
        begin
            lfsr_next = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= 32'd1;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // bit 0 of the stepped state: 1 means d = -1
    assign dir = step[0];

endmodule

FILE: sv/fsg_seq.sv
`timescale 1ns / 1ps
// Sequencer: command handling, clearing pass and the cell-by-cell sweep,
// one grid access per cycle. Depends on fsg_pkg.
module fsg_seq
    import fsg_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64,
    localparam int RW = $clog2(ROWS),
    localparam int CW = $clog2(COLS),
    localparam int AW = RW + CW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cmd_t          cmd,
    output logic          busy,
    output logic          done,
    output res_t          result,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [1:0]    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [1:0]    mem_rdata,
    output logic          draw,
    input  logic          dir
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_WR       = 4'd2;
    localparam logic [3:0] S_RD       = 4'd3;
    localparam logic [3:0] S_RD_EV    = 4'd4;
    localparam logic [3:0] S_CUR      = 4'd5;
    localparam logic [3:0] S_CUR_EV   = 4'd6;
    localparam logic [3:0] S_BELOW_EV = 4'd7;
    localparam logic [3:0] S_PROBE    = 4'd8;
    localparam logic [3:0] S_PROBE_EV = 4'd9;
    localparam logic [3:0] S_WR_DST   = 4'd10;
    localparam logic [3:0] S_WR_SRC   = 4'd11;
    localparam logic [3:0] S_NEXT     = 4'd12;

    // neighbour phases
    localparam logic [1:0] PH_DIAG_EMPTY = 2'd0;
    localparam logic [1:0] PH_DIAG_WATER = 2'd1;
    localparam logic [1:0] PH_SIDE       = 2'd2;

    localparam logic [RW-1:0] ROW_START = RW'(ROWS - 2);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [RW-1:0] f_reg, f_next;
    logic [CW-1:0] c_reg, c_next;
    logic [1:0]    cur_reg, cur_next;
    logic [1:0]    tgt_reg, tgt_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [1:0]    phase_reg, phase_next;
    logic          try_reg, try_next;
    logic          dir_reg, dir_next;
    logic          oob_reg, oob_next;
    logic [AW-1:0] cmd_addr_reg, cmd_addr_next;
    logic [1:0]    cmd_val_reg, cmd_val_next;
    logic          inb_reg, inb_next;
    logic          done_reg, done_next;
    res_t          res_reg, res_next;

    // neighbour address unit, shared by every probe
    logic          go_left;
    logic [RW-1:0] probe_row;
    logic [CW-1:0] probe_col;
    logic          probe_oob;
    logic [RW-1:0] below_row;
    logic [1:0]    want;
    logic          hit;

    always_comb
    begin
        below_row = f_reg + RW'(1);
        go_left   = dir_reg ^ try_reg;
        probe_row = (phase_reg == PH_SIDE) ? f_reg : below_row;
        probe_col = go_left ? (c_reg - CW'(1)) : (c_reg + CW'(1));
        probe_oob = go_left ? (c_reg == '0) : (c_reg == COL_LAST);
        want      = (phase_reg == PH_DIAG_WATER) ? CELL_WATER : CELL_EMPTY;
        hit       = !oob_reg && (mem_rdata == want);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        f_next        = f_reg;
        c_next        = c_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        dst_next      = dst_reg;
        phase_next    = phase_reg;
        try_next      = try_reg;
        dir_next      = dir_reg;
        oob_next      = oob_reg;
        cmd_addr_next = cmd_addr_reg;
        cmd_val_next  = cmd_val_reg;
        inb_next      = inb_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = CELL_EMPTY;
        mem_raddr     = '0;
        draw          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_addr_next = {RW'(cmd.row), CW'(cmd.col)};
                    cmd_val_next  = (cmd.cell_in == CELL_WALL) ? CELL_EMPTY : cmd.cell_in;
                    inb_next      = (32'(cmd.row) < ROWS) && (32'(cmd.col) < COLS);
                    if (cmd.kind == KIND_WRITE)
                    begin
                        state_next = S_WR;
                    end
                    else if (cmd.kind == KIND_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if (cmd.kind == KIND_SWEEP)
                    begin
                        f_next     = ROW_START;
                        c_next     = '0;
                        state_next = S_CUR;
                    end
                    else
                    begin
                        // unused kind: answer at once
                        done_next          = 1'b1;
                        res_next.cell_out  = CELL_EMPTY;
                        res_next.done_kind = cmd.kind;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = CELL_EMPTY;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WR:
            begin
                mem_we             = inb_reg;
                mem_waddr          = cmd_addr_reg;
                mem_wdata          = cmd_val_reg;
                done_next          = 1'b1;
                res_next.cell_out  = CELL_EMPTY;
                res_next.done_kind = KIND_WRITE;
                state_next         = S_IDLE;
            end
            S_RD:
            begin
                mem_raddr  = cmd_addr_reg;
                state_next = S_RD_EV;
            end
            S_RD_EV:
            begin
                done_next          = 1'b1;
                res_next.cell_out  = (inb_reg && mem_rdata != CELL_WALL) ? mem_rdata
                                                                         : CELL_EMPTY;
                res_next.done_kind = KIND_READ;
                state_next         = S_IDLE;
            end
            S_CUR:
            begin
                mem_raddr  = {f_reg, c_reg};
                state_next = S_CUR_EV;
            end
            S_CUR_EV:
            begin
                if (mem_rdata == CELL_SAND || mem_rdata == CELL_WATER)
                begin
                    cur_next   = mem_rdata;
                    mem_raddr  = {below_row, c_reg};
                    dst_next   = {below_row, c_reg};
                    state_next = S_BELOW_EV;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_BELOW_EV:
            begin
                try_next = 1'b0;
                if (mem_rdata == CELL_EMPTY ||
                    (cur_reg == CELL_SAND && mem_rdata == CELL_WATER))
                begin
                    tgt_next   = mem_rdata;
                    state_next = S_WR_DST;
                end
                else
                begin
                    draw       = 1'b1;
                    dir_next   = dir;
                    state_next = S_PROBE;
                    if (cur_reg == CELL_SAND && mem_rdata != CELL_SAND)
                    begin
                        phase_next = PH_DIAG_WATER;
                    end
                    else
                    begin
                        phase_next = PH_DIAG_EMPTY;
                    end
                end
            end
            S_PROBE:
            begin
                mem_raddr  = {probe_row, probe_col};
                dst_next   = {probe_row, probe_col};
                oob_next   = probe_oob;
                state_next = S_PROBE_EV;
            end
            S_PROBE_EV:
            begin
                if (hit)
                begin
                    tgt_next   = mem_rdata;
                    state_next = S_WR_DST;
                end
                else if (!try_reg)
                begin
                    try_next   = 1'b1;
                    state_next = S_PROBE;
                end
                else if (phase_reg == PH_DIAG_EMPTY)
                begin
                    try_next   = 1'b0;
                    state_next = S_PROBE;
                    if (cur_reg == CELL_SAND)
                    begin
                        draw       = 1'b1;
                        dir_next   = dir;
                        phase_next = PH_DIAG_WATER;
                    end
                    else
                    begin
                        // water keeps its direction for the sideways tries
                        phase_next = PH_SIDE;
                    end
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_WR_DST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg;
                mem_wdata  = cur_reg;
                state_next = S_WR_SRC;
            end
            S_WR_SRC:
            begin
                // every move is a swap: source takes what the target held
                mem_we     = 1'b1;
                mem_waddr  = {f_reg, c_reg};
                mem_wdata  = tgt_reg;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (c_reg == COL_LAST)
                begin
                    c_next = '0;
                    if (f_reg == '0)
                    begin
                        done_next          = 1'b1;
                        res_next.cell_out  = CELL_EMPTY;
                        res_next.done_kind = KIND_SWEEP;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        f_next     = f_reg - RW'(1);
                        state_next = S_CUR;
                    end
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_CUR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            f_reg     <= '0;
            c_reg     <= '0;
            phase_reg <= PH_DIAG_EMPTY;
            try_reg   <= 1'b0;
            dir_reg   <= 1'b0;
            oob_reg   <= 1'b0;
            inb_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            f_reg     <= f_next;
            c_reg     <= c_next;
            phase_reg <= phase_next;
            try_reg   <= try_next;
            dir_reg   <= dir_next;
            oob_reg   <= oob_next;
            inb_reg   <= inb_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        tgt_reg      <= tgt_next;
        dst_reg      <= dst_next;
        cmd_addr_reg <= cmd_addr_next;
        cmd_val_reg  <= cmd_val_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
